@@ hw/rtl/nshs_pkg.sv @@
// nshs_pkg: shared types, constants and the cordic arctangent table
// used by the design modules of the nearest site haversine search core
package nshs_pkg;

    localparam int SITES_DEF = 16;
    localparam int CORDIC_STEPS_DEF = 24;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [31:0] CUTOFF_RESET = 32'd26398900;
    localparam logic signed [35:0] CORDIC_GAIN = 36'sd652032874;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [0:0] REG_SITE_COUNT = 1'b0;
    localparam logic [0:0] REG_CUTOFF = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  slot;
        logic [31:0] lat;
        logic [31:0] lon;
    } item_t;

    typedef struct packed {
        logic        found;
        logic [7:0]  slot;
        logic [31:0] lat;
        logic [31:0] lon;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_READ, ST_LATCH, ST_CDLAT, ST_CDLON, ST_COS1, ST_COS2,
        ST_MUL1, ST_MUL2, ST_SUM, ST_NEXT, ST_DONE
    } back_state_t;

    function automatic logic signed [35:0] atan_entry(input logic [4:0] i);
        logic signed [35:0] v;
        begin
            case (i)
                5'd0: v = 36'sd536870912;
                5'd1: v = 36'sd316933406;
                5'd2: v = 36'sd167458907;
                5'd3: v = 36'sd85004756;
                5'd4: v = 36'sd42667331;
                5'd5: v = 36'sd21354465;
                5'd6: v = 36'sd10679838;
                5'd7: v = 36'sd5340245;
                5'd8: v = 36'sd2670163;
                5'd9: v = 36'sd1335087;
                5'd10: v = 36'sd667544;
                5'd11: v = 36'sd333772;
                5'd12: v = 36'sd166886;
                5'd13: v = 36'sd83443;
                5'd14: v = 36'sd41722;
                5'd15: v = 36'sd20861;
                5'd16: v = 36'sd10430;
                5'd17: v = 36'sd5215;
                5'd18: v = 36'sd2608;
                5'd19: v = 36'sd1304;
                5'd20: v = 36'sd652;
                5'd21: v = 36'sd326;
                5'd22: v = 36'sd163;
                5'd23: v = 36'sd81;
                5'd24: v = 36'sd41;
                5'd25: v = 36'sd20;
                5'd26: v = 36'sd10;
                5'd27: v = 36'sd5;
                5'd28: v = 36'sd3;
                5'd29: v = 36'sd1;
                5'd30: v = 36'sd1;
                default: v = 36'sd0;
            endcase
            atan_entry = v;
        end
    endfunction

endpackage

@@ hw/rtl/nshs_cordic.sv @@
// nshs_cordic: iterative cordic rotation, one step per cycle
// depends on nshs_pkg
module nshs_cordic
    import nshs_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic signed [35:0]  angle,
    output logic                done,
    output logic signed [35:0]  cos_out,
    output logic signed [35:0]  sin_out
);

    logic signed [35:0] x_reg, y_reg, z_reg;
    logic signed [35:0] x_next, y_next, z_next;
    logic [4:0] step_reg, step_next;
    logic run_reg, run_next, done_reg, done_next;
    logic signed [35:0] dx, dy;

    always_comb
    begin
        dx = y_reg >>> step_reg;
        dy = x_reg >>> step_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        step_next = step_reg;
        run_next = run_reg;
        done_next = 1'b0;
        if (go)
        begin
            x_next = CORDIC_GAIN;
            y_next = '0;
            z_next = angle;
            step_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!z_reg[35])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - atan_entry(step_reg);
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + atan_entry(step_reg);
            end
            step_next = step_reg + 5'd1;
            if (32'(step_reg) == CORDIC_STEPS - 1)
            begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done = done_reg;
    assign cos_out = x_reg;
    assign sin_out = y_reg;

endmodule

@@ hw/rtl/nshs_front.sv @@
// nshs_front: accepts commands and queues loads and queries in arrival order
// drives the site table write when a load leaves the queue; depends on nshs_pkg
module nshs_front
    import nshs_pkg::*;
#(
    parameter int SITES = SITES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        cmd,
    input  logic [3:0]  site_slot,
    input  logic [31:0] latitude,
    input  logic [31:0] longitude,
    input  logic        pop,
    output logic        busy,
    output logic        q_valid,
    output item_t       q_item,
    output logic        wr_en,
    output logic [$clog2(SITES+1)-1:0] wr_addr,
    output logic [31:0] wr_lat,
    output logic [31:0] wr_lon
);

    item_t q_reg [QUEUE_DEPTH];
    item_t new_item;
    logic [1:0] cnt_reg, cnt_next;
    logic push;

    assign busy = (cnt_reg == 2'(QUEUE_DEPTH));
    assign push = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item = q_reg[0];
    assign new_item = {cmd, 8'(site_slot), latitude, longitude};

    // loads take effect when they leave the queue, in order with queries
    assign wr_en = pop && q_valid && (q_reg[0].cmd == CMD_LOAD) && (32'(q_reg[0].slot) < SITES);
    assign wr_addr = ($clog2(SITES+1))'(q_reg[0].slot);
    assign wr_lat = q_reg[0].lat;
    assign wr_lon = q_reg[0].lon;

    always_comb
    begin
        cnt_next = cnt_reg + 2'(push) - 2'(pop && q_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop && q_valid)
        begin
            if (push)
                q_reg[0] <= new_item;
            else
                q_reg[0] <= q_reg[1];
        end
        else if (push)
            q_reg[cnt_reg[0]] <= new_item;
    end

endmodule

@@ hw/rtl/nshs_back.sv @@
// nshs_back: site table and sequencer computing the haversine term per slot
// depends on nshs_pkg and nshs_cordic
module nshs_back
    import nshs_pkg::*;
#(
    parameter int SITES = SITES_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        pop,
    input  logic        wr_en,
    input  logic [$clog2(SITES+1)-1:0] wr_addr,
    input  logic [31:0] wr_lat,
    input  logic [31:0] wr_lon,
    input  logic [4:0]  site_count,
    input  logic [31:0] cutoff_term,
    output logic        res_valid,
    output result_t     res
);

    localparam int AW = $clog2(SITES+1);
    localparam int IW = (SITES > 1) ? $clog2(SITES) : 1;

    logic [31:0] lat_mem [SITES];
    logic [31:0] lon_mem [SITES];
    logic [31:0] rd_lat_reg, rd_lon_reg;

    back_state_t st_reg, st_next;
    logic [AW-1:0] idx_reg, idx_next, lim;
    logic [AW-1:0] best_idx_reg, best_idx_next;
    logic [31:0] best_reg, best_next;
    logic found_reg, found_next;
    logic [31:0] qlat_reg, qlon_reg;
    logic signed [35:0] h1_reg, h2_reg, c1_reg, c2_reg, p_reg, t_reg;
    logic signed [35:0] ang;
    logic cgo, cdone;
    logic signed [35:0] ccos, csin;
    result_t res_reg;
    logic [31:0] dlat, dlon;
    logic signed [35:0] cl1, cl2;
    logic neg1_reg, neg2_reg;
    logic [35:0] abs_s;
    logic [71:0] sq;
    logic signed [71:0] prod;
    logic signed [36:0] sum;
    logic fin_reg, fin2_reg, out_reg;

    nshs_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .go(cgo), .angle(ang),
        .done(cdone), .cos_out(ccos), .sin_out(csin)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            lat_mem[wr_addr[IW-1:0]] <= wr_lat;
            lon_mem[wr_addr[IW-1:0]] <= wr_lon;
        end
        rd_lat_reg <= lat_mem[idx_reg[IW-1:0]];
        rd_lon_reg <= lon_mem[idx_reg[IW-1:0]];
    end

    assign lim = (32'(site_count) > SITES) ? AW'(SITES) : AW'(site_count);
    assign dlat = rd_lat_reg - qlat_reg;
    assign dlon = rd_lon_reg - qlon_reg;
    assign cl1 = 36'(signed'(qlat_reg));
    assign cl2 = 36'(signed'(rd_lat_reg));
    assign abs_s = csin[35] ? 36'(-csin) : 36'(csin);
    assign sq = 72'(abs_s) * 72'(abs_s);

    always_comb
    begin
        st_next = st_reg;
        idx_next = idx_reg;
        best_idx_next = best_idx_reg;
        best_next = best_reg;
        found_next = found_reg;
        cgo = 1'b0;
        ang = '0;
        pop = 1'b0;
        prod = '0;
        sum = '0;
        unique case (st_reg)
            ST_IDLE:
            begin
                // hold the queue while the best site is read back
                if (q_valid && !fin_reg)
                begin
                    pop = 1'b1;
                    if (q_item.cmd == CMD_QUERY)
                    begin
                        idx_next = '0;
                        best_next = cutoff_term;
                        found_next = 1'b0;
                        best_idx_next = '0;
                        st_next = (lim == '0) ? ST_DONE : ST_READ;
                    end
                end
            end
            ST_READ: st_next = ST_LATCH;
            ST_LATCH:
            begin
                cgo = 1'b1;
                ang = 36'(signed'(dlat)) >>> 1;
                st_next = ST_CDLAT;
            end
            ST_CDLAT:
            begin
                if (cdone)
                begin
                    cgo = 1'b1;
                    ang = 36'(signed'(dlon)) >>> 1;
                    st_next = ST_CDLON;
                end
            end
            ST_CDLON:
            begin
                if (cdone)
                begin
                    cgo = 1'b1;
                    ang = (cl1 > 36'sd1073741824) ? cl1 - 36'sd2147483648 :
                          (cl1 < -36'sd1073741824) ? cl1 + 36'sd2147483648 : cl1;
                    st_next = ST_COS1;
                end
            end
            ST_COS1:
            begin
                if (cdone)
                begin
                    cgo = 1'b1;
                    ang = (cl2 > 36'sd1073741824) ? cl2 - 36'sd2147483648 :
                          (cl2 < -36'sd1073741824) ? cl2 + 36'sd2147483648 : cl2;
                    st_next = ST_COS2;
                end
            end
            ST_COS2:
                if (cdone)
                    st_next = ST_MUL1;
            ST_MUL1:
            begin
                prod = 72'(c1_reg) * 72'(c2_reg);
                st_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                prod = 72'(p_reg) * 72'(h2_reg);
                st_next = ST_SUM;
            end
            ST_SUM:
            begin
                sum = 37'(h1_reg) + 37'(t_reg);
                st_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                if (t_reg < 36'(signed'({4'd0, best_reg})))
                begin
                    best_next = t_reg[31:0];
                    best_idx_next = idx_reg;
                    found_next = 1'b1;
                end
                idx_next = idx_reg + AW'(1);
                st_next = (idx_reg + AW'(1) == lim) ? ST_DONE : ST_READ;
            end
            ST_DONE: st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            idx_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            idx_reg <= (st_reg == ST_DONE) ? best_idx_reg : idx_next;
        end
    end

    // result: table read at the best index, captured once ST_DONE has passed through fin_reg and fin2_reg
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_reg <= 1'b0;
            fin2_reg <= 1'b0;
        end
        else
        begin
            fin_reg <= (st_reg == ST_DONE);
            fin2_reg <= fin_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg <= best_idx_next;
        best_reg <= best_next;
        found_reg <= found_next;
        if (st_reg == ST_IDLE && q_valid)
        begin
            qlat_reg <= q_item.lat;
            qlon_reg <= q_item.lon;
        end
        if (st_reg == ST_CDLAT && cdone)
            h1_reg <= 36'(sq >> 28);
        if (st_reg == ST_CDLON && cdone)
        begin
            h2_reg <= 36'(sq >> 28);
            neg1_reg <= (cl1 > 36'sd1073741824) || (cl1 < -36'sd1073741824);
        end
        if (st_reg == ST_COS1 && cdone)
        begin
            c1_reg <= neg1_reg ? -ccos : ccos;
            neg2_reg <= (cl2 > 36'sd1073741824) || (cl2 < -36'sd1073741824);
        end
        if (st_reg == ST_COS2 && cdone)
            c2_reg <= neg2_reg ? -ccos : ccos;
        if (st_reg == ST_MUL1)
            p_reg <= 36'(prod >>> 30);
        if (st_reg == ST_MUL2)
            t_reg <= 36'(prod >>> 30);
        if (st_reg == ST_SUM)
            t_reg <= sum[36] ? 36'sd0 :
                     (sum > 37'sd4294967295) ? 36'sd4294967295 : 36'(sum);
        if (fin2_reg)
        begin
            res_reg.found <= found_reg;
            res_reg.slot <= found_reg ? 8'(best_idx_reg) : 8'd0;
            res_reg.lat <= found_reg ? rd_lat_reg : 32'd0;
            res_reg.lon <= found_reg ? rd_lon_reg : 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_reg <= 1'b0;
        else
            out_reg <= fin2_reg;
    end

    assign res_valid = out_reg;
    assign res = res_reg;

endmodule

@@ hw/rtl/nearest_site_haversine_search_core.sv @@
// nearest site haversine search core: a load is written to the site table as it leaves the queue,
// a query steps through each site with the shared cordic unit
// the front queues two commands in order; busy rises when the queue is full
// result strobe lasts one cycle and cannot be stalled
// asynchronous active-low reset clears control and count and presets cutoff; site table not cleared
module nearest_site_haversine_search_core
    import nshs_pkg::*;
#(
    parameter int SITES = SITES_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cmd,
    input  logic [3:0]  site_slot,
    input  logic signed [31:0] latitude,
    input  logic signed [31:0] longitude,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        done,
    output logic        found,
    output logic [3:0]  nearest_slot,
    output logic signed [31:0] nearest_latitude,
    output logic signed [31:0] nearest_longitude
);

    logic [4:0] site_count_reg;
    logic [31:0] cutoff_reg;
    logic q_valid, pop, wr_en, res_valid;
    item_t q_item;
    result_t res;
    logic [$clog2(SITES+1)-1:0] wr_addr;
    logic [31:0] wr_lat, wr_lon;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            site_count_reg <= '0;
            cutoff_reg <= CUTOFF_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SITE_COUNT: site_count_reg <= cfg_data[4:0];
                REG_CUTOFF: cutoff_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    nshs_front #(.SITES(SITES)) u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd), .site_slot(site_slot),
        .latitude(latitude), .longitude(longitude), .pop(pop), .busy(busy),
        .q_valid(q_valid), .q_item(q_item), .wr_en(wr_en), .wr_addr(wr_addr),
        .wr_lat(wr_lat), .wr_lon(wr_lon)
    );

    nshs_back #(.SITES(SITES), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item), .pop(pop),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_lat(wr_lat), .wr_lon(wr_lon),
        .site_count(site_count_reg), .cutoff_term(cutoff_reg),
        .res_valid(res_valid), .res(res)
    );

    assign done = res_valid;
    assign found = res.found;
    assign nearest_slot = res.slot[3:0];
    assign nearest_latitude = res.lat;
    assign nearest_longitude = res.lon;

endmodule

@@ hw/rtl/nshs_checker.sv @@
// nshs_port_props: port-level assertions for the search core
// depends on nearest_site_haversine_search_core ports
module nshs_port_props (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        found,
    input logic [3:0]  nearest_slot,
    input logic [31:0] nearest_latitude,
    input logic [31:0] nearest_longitude
);

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held longer than one cycle");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (nearest_slot == 4'd0 && nearest_latitude == 32'd0
        && nearest_longitude == 32'd0)) else $error("not found result not zero");

    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown({found, nearest_slot, nearest_latitude, nearest_longitude}))
        else $error("result has unknown bits");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && !busy)) else $error("busy rose without a transfer");

endmodule

bind nearest_site_haversine_search_core nshs_port_props u_nshs_port_props (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .found(found), .nearest_slot(nearest_slot), .nearest_latitude(nearest_latitude),
    .nearest_longitude(nearest_longitude)
);
